// ===== sv/lru_key_value_cache_unit_assert.svh =====
// assertion macros for the lru key-value cache unit
// no dependencies; included by files that carry concurrent assertions
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define LKVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LKVC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lkvc_pkg.sv =====
// shared constants, types and state encoding for the lru key-value cache
// no dependencies
`default_nettype none
package lkvc_pkg;
    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(ENTRIES);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } t_dp_cmd;
endpackage
`default_nettype wire

// ===== sv/lkvc_if.sv =====
// valid/ready channel interfaces: input items, results and capacity writes
// depends on lkvc_pkg
`default_nettype none
interface lkvc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic signed [lkvc_pkg::KEY_W-1:0]   key;
    logic signed [lkvc_pkg::VAL_W-1:0]   value;
    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lkvc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic signed [lkvc_pkg::VAL_W-1:0]   read_value;
    modport source (output valid, found, read_value, input ready);
    modport sink   (input valid, found, read_value, output ready);
endinterface

interface lkvc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lkvc_pkg::CAP_W-1:0]          capacity;
    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface
`default_nettype wire

// ===== sv/lkvc_ctrl.sv =====
// sequencing state machine: accept, lookup, commit, result valid
// depends on lkvc_pkg
`default_nettype none
module lkvc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    input  wire logic              i_res_ready,
    output logic                   o_res_valid,
    output lkvc_pkg::t_dp_cmd      o_cmd
);
    import lkvc_pkg::*;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   w_res_free;

    assign w_res_free = !r_res_valid || i_res_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_item_valid) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_COMMIT;
            S_COMMIT: if (w_res_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                o_cmd.load   = i_item_valid;
            end
            S_LOOKUP: o_cmd.lookup = 1'b1;
            S_COMMIT: o_cmd.commit = w_res_free;
            default: begin
                o_item_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (o_cmd.commit) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;
endmodule
`default_nettype wire

// ===== sv/lkvc_dp.sv =====
// entry store, key compare, recency ranks, victim choice and result register
// depends on lkvc_pkg
`default_nettype none
module lkvc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lkvc_pkg::t_dp_cmd             i_cmd,
    input  wire logic                          i_mode,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0] i_value,
    input  wire logic                          i_cap_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]    i_cap,
    output logic                               o_found,
    output logic signed [lkvc_pkg::VAL_W-1:0]  o_read_value
);
    import lkvc_pkg::*;

    // latched item
    logic             r_mode;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CAP_W-1:0] r_cap;

    // entry store
    logic [KEY_W-1:0] r_keys  [ENTRIES];
    logic [VAL_W-1:0] r_vals  [ENTRIES];
    logic [IDX_W-1:0] r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0] r_count;

    // lookup results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_slot;
    logic [IDX_W-1:0] r_victim;

    logic             r_found;
    logic [VAL_W-1:0] r_read_value;

    // lookup logic
    logic [ENTRIES-1:0] w_match;
    logic             w_hit;
    logic [IDX_W-1:0] w_hit_slot;
    logic [IDX_W-1:0] w_lru_slot;
    logic             w_lru_any;
    logic [IDX_W-1:0] w_free_slot;
    logic [CNT_W-1:0] w_eff_cap;
    logic             w_evict;

    // commit logic
    logic [IDX_W-1:0] w_tgt;
    logic             w_tgt_hit;
    logic             w_touch;
    logic [IDX_W-1:0] w_tgt_rank;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_keys[i] == r_key);
        end
    end

    always_comb begin
        w_hit       = |w_match;
        w_hit_slot  = '0;
        w_free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) w_hit_slot = IDX_W'(i);
            if (!r_valid[i]) w_free_slot = IDX_W'(i);
        end
    end

    // oldest valid entry, lowest slot on a tie
    always_comb begin
        w_lru_slot = '0;
        w_lru_any  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && (!w_lru_any || (r_rank[i] > r_rank[w_lru_slot]))) begin
                w_lru_slot = IDX_W'(i);
                w_lru_any  = 1'b1;
            end
        end
    end

    // capacity clamped to 1..ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (CNT_W'(r_cap) > CAP_MAX) begin
            w_eff_cap = CAP_MAX;
        end else begin
            w_eff_cap = CNT_W'(r_cap);
        end
        w_evict = r_count >= w_eff_cap;
    end

    assign w_tgt      = r_hit ? r_hit_slot : r_victim;
    assign w_tgt_hit  = r_hit;
    assign w_touch    = r_hit || (r_mode == MODE_PUT);
    assign w_tgt_rank = r_rank[w_tgt];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.lookup) begin
            r_hit      <= w_hit;
            r_hit_slot <= w_hit_slot;
            r_victim   <= w_evict ? w_lru_slot : w_free_slot;
        end
        if (i_cmd.commit) begin
            r_found      <= r_hit;
            r_read_value <= (r_hit && (r_mode == MODE_GET)) ? r_vals[r_hit_slot] : '0;
            if (r_mode == MODE_PUT) begin
                r_vals[w_tgt] <= r_value;
                if (!r_hit) r_keys[w_tgt] <= r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else begin
            if (i_cap_we) r_cap <= i_cap;
            if (i_cmd.commit && w_touch) begin
                // age entries newer than the target, or all others on an insert
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == w_tgt) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (!w_tgt_hit || (r_rank[i] < w_tgt_rank))) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                if (!r_hit && !r_valid[w_tgt]) begin
                    r_valid[w_tgt] <= 1'b1;
                    r_count        <= r_count + 1'b1;
                end
            end
        end
    end

    assign o_found      = r_found;
    assign o_read_value = r_read_value;
endmodule
`default_nettype wire

// ===== sv/lru_key_value_cache_unit.sv =====
// lru key-value cache top level: controller, datapath and channel ports
// depends on lkvc_pkg, lkvc_if, lkvc_ctrl, lkvc_dp and the assertion header
//
// usage
//   i_item  : item channel (mode, key, value); mode get looks up key, mode put
//             inserts or updates key with value
//   o_result: one transaction per item (found, read_value); read_value is the
//             stored value on a get hit and zero on a get miss and on every put
//   i_cfg   : capacity write, always ready; write only while no item is in flight
// timing
//   an item is accepted in the idle state; the lookup state then compares the key
//   with all eight entries and picks the victim, and the commit state updates the
//   store and loads the result register, which then holds the valid result
//   a new item is taken only after the previous one has passed the lookup then
//   commit sequence of the controller over the shared entry store
//   a waiting result does not block acceptance of the next item; the commit of
//   that next item waits only while the result register is still full
// reset
//   synchronous, active low: store empty, all ranks zero, capacity 8, no result
`default_nettype none
`include "lru_key_value_cache_unit_assert.svh"
module lru_key_value_cache_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lkvc_in_if.sink     i_item,
    lkvc_out_if.source  o_result,
    lkvc_cfg_if.sink    i_cfg
);
    import lkvc_pkg::*;

    t_dp_cmd w_cmd;

    // capacity register lives in the datapath and takes a write every cycle
    assign i_cfg.ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_res_ready  (o_result.ready),
        .o_res_valid  (o_result.valid),
        .o_cmd        (w_cmd)
    );

    lkvc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_mode       (i_item.mode),
        .i_key        (i_item.key),
        .i_value      (i_item.value),
        .i_cap_we     (i_cfg.valid),
        .i_cap        (i_cfg.capacity),
        .o_found      (o_result.found),
        .o_read_value (o_result.read_value)
    );

    // an accepted item goes straight to the compare cycle
    `LKVC_ASSERT_NEXT(a_accept_then_lookup, i_clk, i_rst_n, i_item.valid && i_item.ready, w_cmd.lookup)
    // no new item is taken while the store is being updated
    `LKVC_ASSERT_SAME(a_no_accept_in_commit, i_clk, i_rst_n, w_cmd.commit || w_cmd.lookup, !i_item.ready)
    // a result appears only after a commit
    `LKVC_ASSERT_SAME(a_result_from_commit, i_clk, i_rst_n, $rose(o_result.valid), $past(w_cmd.commit))
endmodule
`default_nettype wire

// ===== tb/lru_key_value_cache_unit_tb.sv =====
// self-checking testbench for the lru key-value cache unit: directed and random
// get/put traffic over several capacity settings, checked against an lru predictor
// depends on lkvc_pkg, lkvc_if and lru_key_value_cache_unit
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;
    import lkvc_pkg::*;

    localparam int          CLK_PERIOD     = 8;
    localparam int          RESET_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          POOL_SIZE      = 12;
    localparam int          RANDOM_ITEMS   = 1250;
    localparam int          PHASES         = 12;
    localparam int          DRAIN_CYCLES   = 20;

    // one expected reply of the cache
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
    } t_reply;

    // lru predictor plus the queue of replies still owed by the block
    class lru_tracker;
        logic [KEY_W-1:0] keys[ENTRIES];
        logic [VAL_W-1:0] vals[ENTRIES];
        bit               live[ENTRIES];
        int unsigned      rank[ENTRIES];
        int unsigned      fill;
        logic [CAP_W-1:0] capacity;
        t_reply           owed_replies[$];
        int unsigned      errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < ENTRIES; i++) begin
                live[i] = 1'b0;
                rank[i] = 0;
            end
            fill = 0;
            capacity = CAP_RESET;
            owed_replies.delete();
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        // zero acts as one, anything above the store size saturates
        function int unsigned cap_in_force();
            int unsigned c;
            c = capacity;
            if (c == 0) c = 1;
            if (c > ENTRIES) c = ENTRIES;
            return c;
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && keys[i] == key) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < ENTRIES; i++)
                if (!live[i]) return i;
            return -1;
        endfunction

        function int oldest_slot();
            int best;
            best = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && (best < 0 || rank[i] > rank[best])) best = i;
            return best;
        endfunction

        // entries newer than s age by one, s becomes the newest
        function void make_newest(int s);
            int unsigned r;
            r = rank[s];
            for (int i = 0; i < ENTRIES; i++)
                if (live[i] && i != s && rank[i] < r) rank[i]++;
            rank[s] = 0;
        endfunction

        function void note_access(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
            t_reply exp;
            int     s;
            s = find_slot(key);
            exp.found = (s >= 0);
            exp.read_value = '0;
            if (mode == MODE_GET) begin
                if (s >= 0) begin
                    exp.read_value = vals[s];
                    make_newest(s);
                end
            end else if (s >= 0) begin
                vals[s] = value;
                make_newest(s);
            end else begin
                s = (fill >= cap_in_force()) ? oldest_slot() : free_slot();
                if (s < 0) s = oldest_slot();
                if (live[s]) begin
                    // reused victim holds the top rank, so aging the rest is safe
                    rank[s] = ENTRIES;
                    make_newest(s);
                end else begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (live[i]) rank[i]++;
                    live[s] = 1'b1;
                    rank[s] = 0;
                    fill++;
                end
                keys[s] = key;
                vals[s] = value;
            end
            owed_replies.push_back(exp);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_reply(logic found, logic [VAL_W-1:0] read_value);
            t_reply exp;
            if (owed_replies.size() == 0) begin
                report($sformatf("reply found=%0b value=%h with no access outstanding",
                                 found, read_value));
            end else begin
                exp = owed_replies.pop_front();
                if (found !== exp.found)
                    report($sformatf("found %0b, expected %0b", found, exp.found));
                if (read_value !== exp.read_value)
                    report($sformatf("read_value %h, expected %h",
                                     read_value, exp.read_value));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lkvc_in_if  item_ch();
    lkvc_out_if result_ch();
    lkvc_cfg_if cfg_ch();

    lru_key_value_cache_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    lru_tracker       tracker;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    bit               quiet;          // no gaps and no stalls while set
    int unsigned      idle_cycles;
    bit               progress;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // fresh keys for a phase, corner patterns mixed in
    function automatic void refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(0, 11))
                0:       key_pool[i] = 32'h8000_0000;
                1:       key_pool[i] = 32'h7fff_ffff;
                2:       key_pool[i] = 32'hffff_ffff;
                3:       key_pool[i] = 32'h0000_0000;
                default: key_pool[i] = $urandom;
            endcase
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 8) return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // one get or put transaction; valid stays high afterwards for back-to-back items
    task automatic cache_access(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode  <= mode;
        item_ch.key   <= key;
        item_ch.value <= value;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic random_access();
        logic mode;
        mode = ($urandom_range(0, 99) < 48) ? MODE_PUT : MODE_GET;
        cache_access(mode, pick_key(), $urandom);
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
    endtask

    // sender holds off until every owed reply has come back
    task automatic wait_drain();
        stop_items();
        while (tracker.owed_replies.size() != 0) @(posedge i_clk);
    endtask

    // capacity is only changed with the cache idle
    task automatic write_capacity(logic [CAP_W-1:0] c);
        wait_drain();
        @(negedge i_clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result sink: random stalls, none in quiet stretches
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0 && !quiet) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                stall_left = 0;
                if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    // monitor: every handshake is taken at the rising edge, plus the watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            progress = 1'b0;
            if (item_ch.valid && item_ch.ready) begin
                tracker.note_access(item_ch.mode, item_ch.key, item_ch.value);
                progress = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                tracker.set_capacity(cfg_ch.capacity);
                progress = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                tracker.check_reply(result_ch.found, result_ch.read_value);
                progress = 1'b1;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL lru_key_value_cache_unit");
                $finish;
            end
        end
    end

    initial begin
        logic [CAP_W-1:0] phase_caps[PHASES];
        int unsigned      per_phase;

        tracker = new();
        phase_caps = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2, 4'd9, 4'd6, 4'd4,
                       4'd7, 4'd5, 4'd8};
        per_phase = RANDOM_ITEMS / PHASES + 1;
        quiet = 1'b0;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.mode    = MODE_GET;
        item_ch.key     = '0;
        item_ch.value   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = CAP_RESET;
        idle_cycles     = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset capacity of eight, extreme keys and values
        cache_access(MODE_GET, 32'h0000_0000, 32'hdead_beef);   // get on empty store
        cache_access(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
        cache_access(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
        cache_access(MODE_GET, 32'h8000_0000, 32'h1234_5678);
        cache_access(MODE_GET, 32'h7fff_ffff, 32'h0000_0000);
        cache_access(MODE_PUT, 32'h8000_0000, 32'h0000_0000);   // update a present key
        cache_access(MODE_GET, 32'h8000_0000, 32'hffff_ffff);
        cache_access(MODE_PUT, 32'h0000_0000, 32'hffff_ffff);
        cache_access(MODE_PUT, 32'hffff_ffff, 32'h0000_0001);
        // fill all eight slots, then two more inserts evict the oldest entries
        for (int k = 1; k <= 6; k++)
            cache_access(MODE_PUT, k, 32'h0000_1000 + k);
        cache_access(MODE_GET, 32'h7fff_ffff, 32'h0);           // evicted by now
        cache_access(MODE_GET, 32'h0000_0006, 32'h0);
        cache_access(MODE_PUT, 32'h0000_0006, 32'h5555_aaaa);   // full store, present key

        // capacity of one: every new key replaces the oldest entry
        write_capacity(4'd1);
        cache_access(MODE_PUT, 32'h0000_00aa, 32'haaaa_5555);
        cache_access(MODE_GET, 32'h0000_0006, 32'h0);
        cache_access(MODE_GET, 32'h0000_00aa, 32'h0);
        // capacity zero acts as one
        write_capacity(4'd0);
        cache_access(MODE_PUT, 32'h0000_00bb, 32'h0bad_f00d);
        cache_access(MODE_GET, 32'h0000_00aa, 32'h0);
        cache_access(MODE_GET, 32'h0000_00bb, 32'h0);

        // random phases over many capacity settings, including zero and values above the store size
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p]);
            refresh_pool();
            for (int n = 0; n < per_phase; n++) begin
                if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
                if (p == PHASES / 2 && n == per_phase / 2) wait_drain();
                random_access();
            end
        end
        quiet = 1'b0;

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.owed_replies.size() != 0)
            tracker.report($sformatf("%0d replies never arrived",
                                     tracker.owed_replies.size()));
        if (tracker.errors == 0) begin
            $display("PASS lru_key_value_cache_unit");
        end else begin
            $display("FAIL lru_key_value_cache_unit");
        end
        $finish;
    end
endmodule
